// ===== design/psn_pkg.sv =====
// Shared constants and widths for the point set normalisation block
`default_nettype none
package psn_pkg;
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = COORD_BITS + ADDR_W;
  localparam int SQ_W       = 2 * SUM_W + 1;
  localparam int SQ_E       = SQ_W + (SQ_W % 2);
  localparam int ROOT_W     = SUM_W + 1;
  localparam int DSUM_W     = ROOT_W + ADDR_W;
  localparam int P1_W       = SUM_W + CNT_W;
  localparam int K_W        = 31;
  localparam int NUM_W      = P1_W + K_W;
  localparam int DIV_W      = 64;
  localparam int Q_W        = 16;

  localparam logic [K_W-1:0] SQRT2_Q30 = 31'd1518500250;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_OVF  = 2'd2;
endpackage
`default_nettype wire

// ===== design/psn_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle
`default_nettype none
module psn_sqrt
  import psn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   value,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);
  logic            busy_r;
  logic            done_r;
  logic [SQ_E-1:0] v_r;
  logic [SQ_E-1:0] r_r;
  logic [SQ_E-1:0] bit_r;
  logic [SQ_E-1:0] trial;

  assign trial = r_r + bit_r;

  // control: run until the trial bit has reached position zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r && bit_r == SQ_E'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // datapath: subtract the trial value where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= SQ_E'(value);
      r_r   <= '0;
      bit_r <= SQ_E'(1) << (SQ_E - 2);
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== design/psn_div.sv =====
// Restoring divider for the rounded Q4.12 quotient, one bit per cycle
`default_nettype none
module psn_div
  import psn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DSUM_W-1:0] dsum,
  output logic                   done,
  output logic                   big,
  output logic [Q_W-1:0]         quot
);
  logic             busy_r;
  logic             done_r;
  logic             big_r;
  logic [3:0]       cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dsh_r;
  logic [Q_W-1:0]   q_r;
  logic [DIV_W-1:0] n64;
  logic [DIV_W-1:0] den64;
  logic             ovf;

  // add half the divisor for round to nearest
  assign n64   = DIV_W'(num) + (DIV_W'(dsum) << 17);
  assign den64 = DIV_W'(dsum) << 18;
  assign ovf   = n64 >= (den64 << Q_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= !ovf;
        done_r <= ovf;
      end else if (busy_r && cnt_r == 4'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      big_r <= ovf;
      rem_r <= n64;
      dsh_r <= den64 << (Q_W - 1);
      cnt_r <= 4'(Q_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[Q_W-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 4'd1;
    end
  end

  assign done = done_r;
  assign big  = big_r;
  assign quot = q_r;
endmodule
`default_nettype wire

// ===== design/point_set_normalization.sv =====
// Isotropic normalisation of a 2D point set: store, sequencer and output register
//
// Input channel: in_point_x, in_point_y (unsigned Q12.4) and in_last_point with
// in_valid / in_stall. Output channel: out_norm_x, out_norm_y (signed Q4.12),
// out_last_result and out_status with out_valid / out_stall.
// Points load at one word per cycle into the point store. The word that carries
// in_last_point closes the set; in_stall then stays high until the last result of
// the set has entered the output register.
// After the closing word, the first pass is paced per point by the bit-serial
// square root (23 steps), and the second pass per point by the shared divider
// that runs 16 steps for x and then for y.
// A zero spread set goes from the read state straight to the output state for
// each point; a set that overflowed the store gives a single word with status 2.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset (rst_n low, synchronous) empties the set and the output register; the
// store contents are left as they are and are rewritten before use.
`default_nettype none
module point_set_normalization
  import psn_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [15:0]           in_point_x,
  input  wire logic [15:0]           in_point_y,
  input  wire logic                  in_last_point,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [15:0]         out_norm_x,
  output logic signed [15:0]         out_norm_y,
  output logic                       out_last_result,
  output logic [1:0]                 out_status
);
  typedef enum logic [15:0] {
    S_LOAD    = 16'b0000_0000_0000_0001,
    S_OVF     = 16'b0000_0000_0000_0010,
    S_P1_RD   = 16'b0000_0000_0000_0100,
    S_P1_DEV  = 16'b0000_0000_0000_1000,
    S_P1_SQ   = 16'b0000_0000_0001_0000,
    S_P1_ADD  = 16'b0000_0000_0010_0000,
    S_P1_WAIT = 16'b0000_0000_0100_0000,
    S_P2_RD   = 16'b0000_0000_1000_0000,
    S_P2_DEV  = 16'b0000_0001_0000_0000,
    S_P2_MUL1 = 16'b0000_0010_0000_0000,
    S_P2_MUL2 = 16'b0000_0100_0000_0000,
    S_P2_DIVX = 16'b0000_1000_0000_0000,
    S_P2_WX   = 16'b0001_0000_0000_0000,
    S_P2_DIVY = 16'b0010_0000_0000_0000,
    S_P2_WY   = 16'b0100_0000_0000_0000,
    S_P2_OUT  = 16'b1000_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_data_r;

  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] idx_r;
  logic [SUM_W-1:0]  sum_x_r, sum_y_r;
  logic [DSUM_W-1:0] dsum_r;
  logic              ovf_r;

  logic [SUM_W-1:0]  magx_r, magy_r;
  logic              negx_r, negy_r;
  logic [2*SUM_W-1:0] sqx_r, sqy_r;
  logic [P1_W-1:0]   p1x_r, p1y_r;
  logic [NUM_W-1:0]  numx_r, numy_r;
  logic [Q_W-1:0]    qx_r;
  logic              bigx_r;

  logic              out_valid_r;
  logic [15:0]       out_x_r, out_y_r;
  logic              out_last_r;
  logic [1:0]        out_status_r;

  logic [COORD_BITS-1:0] in_x, in_y, rd_x, rd_y;
  logic              accept, slot_free, last_idx;
  logic [SUM_W-1:0]  ax, ay;
  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] root;
  logic              div_start, div_done, div_big;
  logic [NUM_W-1:0]  div_num;
  logic [Q_W-1:0]    div_q;
  logic [15:0]       res_x, res_y;

  assign in_x      = in_point_x[COORD_BITS-1:0];
  assign in_y      = in_point_y[COORD_BITS-1:0];
  assign rd_x      = rd_data_r[2*COORD_BITS-1:COORD_BITS];
  assign rd_y      = rd_data_r[COORD_BITS-1:0];
  assign in_stall  = (state_r != S_LOAD);
  assign accept    = in_valid && (state_r == S_LOAD);
  assign slot_free = !out_valid_r || !out_stall;
  assign last_idx  = (idx_r == ADDR_W'(count_r - CNT_W'(1)));

  // point store: write on load, read the current index every cycle
  always_ff @(posedge clk) begin
    if (accept && count_r < CNT_W'(MAX_POINTS)) begin
      mem[count_r[ADDR_W-1:0]] <= {in_x, in_y};
    end
    rd_data_r <= mem[idx_r];
  end

  // deviation n*c - S, split into magnitude and sign
  assign ax = SUM_W'(count_r * rd_x);
  assign ay = SUM_W'(count_r * rd_y);

  always_ff @(posedge clk) begin
    if (state_r == S_P1_DEV || state_r == S_P2_DEV) begin
      negx_r <= ax < sum_x_r;
      negy_r <= ay < sum_y_r;
      magx_r <= (ax < sum_x_r) ? sum_x_r - ax : ax - sum_x_r;
      magy_r <= (ay < sum_y_r) ? sum_y_r - ay : ay - sum_y_r;
    end
    if (state_r == S_P1_SQ) begin
      sqx_r <= magx_r * magx_r;
      sqy_r <= magy_r * magy_r;
    end
    if (state_r == S_P2_MUL1) begin
      p1x_r <= magx_r * count_r;
      p1y_r <= magy_r * count_r;
    end
    if (state_r == S_P2_MUL2) begin
      numx_r <= p1x_r * SQRT2_Q30;
      numy_r <= p1y_r * SQRT2_Q30;
    end
    if (state_r == S_P2_WX && div_done) begin
      qx_r   <= div_q;
      bigx_r <= div_big;
    end
  end

  assign sq_start  = (state_r == S_P1_ADD);
  assign div_start = (state_r == S_P2_DIVX) || (state_r == S_P2_DIVY);
  assign div_num   = (state_r == S_P2_DIVX) ? numx_r : numy_r;

  psn_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (SQ_W'(sqx_r) + SQ_W'(sqy_r)),
    .done  (sq_done),
    .root  (root)
  );

  psn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .dsum  (dsum_r),
    .done  (div_done),
    .big   (div_big),
    .quot  (div_q)
  );

  // saturate and apply sign
  function automatic logic [15:0] sat_q(input logic neg, input logic big,
                                        input logic [Q_W-1:0] q);
    logic [15:0] r;
    if (neg) begin
      r = (big || q > 16'd32768) ? 16'h8000 : 16'(16'd0 - q);
    end else begin
      r = (big || q > 16'd32767) ? 16'h7FFF : q;
    end
    return r;
  endfunction

  assign res_x = sat_q(negx_r, bigx_r, qx_r);
  assign res_y = sat_q(negy_r, div_big, div_q);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept && in_last_point) begin
          state_nxt = (ovf_r || count_r == CNT_W'(MAX_POINTS)) ? S_OVF : S_P1_RD;
        end
      end
      S_OVF:     if (slot_free) state_nxt = S_LOAD;
      S_P1_RD:   state_nxt = S_P1_DEV;
      S_P1_DEV:  state_nxt = S_P1_SQ;
      S_P1_SQ:   state_nxt = S_P1_ADD;
      S_P1_ADD:  state_nxt = S_P1_WAIT;
      S_P1_WAIT: if (sq_done) state_nxt = last_idx ? S_P2_RD : S_P1_RD;
      S_P2_RD:   state_nxt = (dsum_r == '0) ? S_P2_OUT : S_P2_DEV;
      S_P2_DEV:  state_nxt = S_P2_MUL1;
      S_P2_MUL1: state_nxt = S_P2_MUL2;
      S_P2_MUL2: state_nxt = S_P2_DIVX;
      S_P2_DIVX: state_nxt = S_P2_WX;
      S_P2_WX:   if (div_done) state_nxt = S_P2_DIVY;
      S_P2_DIVY: state_nxt = S_P2_WY;
      S_P2_WY:   if (div_done) state_nxt = S_P2_OUT;
      S_P2_OUT:  if (slot_free) state_nxt = last_idx ? S_LOAD : S_P2_RD;
      default:   state_nxt = S_LOAD;
    endcase
  end

  // set state: counts, sums, distance sum, index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      dsum_r  <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (count_r < CNT_W'(MAX_POINTS)) begin
          count_r <= count_r + CNT_W'(1);
          sum_x_r <= sum_x_r + SUM_W'(in_x);
          sum_y_r <= sum_y_r + SUM_W'(in_y);
        end else begin
          ovf_r <= 1'b1;
        end
        idx_r  <= '0;
        dsum_r <= '0;
      end
      if (state_r == S_P1_WAIT && sq_done) begin
        dsum_r <= dsum_r + DSUM_W'(root);
        idx_r  <= last_idx ? '0 : idx_r + ADDR_W'(1);
      end
      if (state_r == S_P2_OUT && slot_free && !last_idx) begin
        idx_r <= idx_r + ADDR_W'(1);
      end
      // drop the set once its final word is out
      if ((state_r == S_OVF && slot_free) ||
          (state_r == S_P2_OUT && slot_free && last_idx)) begin
        count_r <= '0;
        sum_x_r <= '0;
        sum_y_r <= '0;
        dsum_r  <= '0;
        ovf_r   <= 1'b0;
        idx_r   <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OVF && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_P2_OUT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OVF && slot_free) begin
      out_x_r      <= '0;
      out_y_r      <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= STATUS_OVF;
    end else if (state_r == S_P2_OUT && slot_free) begin
      out_last_r <= last_idx;
      if (dsum_r == '0) begin
        out_x_r      <= '0;
        out_y_r      <= '0;
        out_status_r <= STATUS_ZERO;
      end else begin
        out_x_r      <= res_x;
        out_y_r      <= res_y;
        out_status_r <= STATUS_OK;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_norm_x      = out_x_r;
  assign out_norm_y      = out_y_r;
  assign out_last_result = out_last_r;
  assign out_status      = out_status_r;
endmodule
`default_nettype wire

// ===== design/psn_chk.sv =====
// Port-level checks for the point set normalisation block
`default_nettype none
module psn_chk
  import psn_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic signed [15:0] out_norm_x,
  input wire logic signed [15:0] out_norm_y,
  input wire logic              out_last_result,
  input wire logic [1:0]        out_status
);
  // hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // overflow word closes the set
  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_OVF |-> out_last_result)
    else $error("overflow word without last flag");

  // degenerate sets give zero coordinates
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_norm_x == 16'sd0 && out_norm_y == 16'sd0)
    else $error("non-zero coordinates on flagged word");

  // no loading while a set is still being emitted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> in_stall)
    else $error("input taken during emission");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind point_set_normalization psn_chk u_psn_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_norm_x      (out_norm_x),
  .out_norm_y      (out_norm_y),
  .out_last_result (out_last_result),
  .out_status      (out_status)
);
`default_nettype wire
